// File: rtl/core/led_blink_pattern_sequencer_defines.svh
// Assertion macros used by the checker file of the LED pattern sequencer.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define LBPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LBPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lbps_pkg.sv
package lbps_pkg;

  // Fixed widths of the request fields.
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned DUR_IN_W = 16;
  localparam int unsigned COUNT_W  = 4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_START  = 2'd2,
    OP_MANUAL = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_needed;
    logic walk_end;
  } status_t;

endpackage

// File: rtl/core/led_blink_pattern_sequencer.sv
// Steps: a write, a manual LED request or a tick on an idle pattern is captured,
// executed and finished; a start or a live tick also walks up to MAX_ENTRIES
// table entries in between, one entry per cycle through the table port.
// Requests: a new request is not taken while one is in flight, since busy stays high
// until the done_o cycle ends and the next request is taken in the idle cycle after.
// Reset: asynchronous, active low, clears the pattern and LED; receiver cannot stall.

// The sequencer drives one LED from a table of signed millisecond durations.
// Even entries are on-times, odd entries are off-times, zero entries are skipped
// and a negative entry halts the pattern. A small state machine in lbps_ctrl
// steps each request through capture, execute and an optional table walk, and
// lbps_datapath holds the table, the pattern state and the walk accumulators.
// The table is read through one registered port, so the walk visits one entry per
// cycle; a tick's walk stops early once the elapsed time is inside the running sum.
module led_blink_pattern_sequencer import lbps_pkg::*; #(
  parameter int unsigned MAX_ENTRIES   = 8,
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode_i,
  input  logic [INDEX_W-1:0]         entry_index_i,
  input  logic signed [DUR_IN_W-1:0] duration_i,
  input  logic [COUNT_W-1:0]         entry_count_i,
  input  logic                       led_value_i,
  output logic                       done_o,
  output logic                       led_on_o,
  output logic                       running_o,
  output logic                       pattern_valid_o
);

  // Command and status between the controller and the datapath.
  cmd_t    cmd;
  status_t status;

  lbps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // The datapath captures the request when the controller accepts it, so the
  // input ports are free to change while the request is being worked on.
  lbps_datapath #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .DURATION_BITS (DURATION_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .opcode_i        (opcode_i),
    .entry_index_i   (entry_index_i),
    .duration_i      (duration_i),
    .entry_count_i   (entry_count_i),
    .led_value_i     (led_value_i),
    .led_on_o        (led_on_o),
    .running_o       (running_o),
    .pattern_valid_o (pattern_valid_o)
  );

endmodule

// File: rtl/core/lbps_ctrl.sv
module lbps_ctrl import lbps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = status_i.walk_needed ? ST_WALK : ST_FINISH;
      end
      ST_WALK: begin
        if (status_i.walk_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && start_i;
    cmd_o.exec    = (state_q == ST_EXEC);
    cmd_o.step    = (state_q == ST_WALK);
    busy_o        = (state_q != ST_IDLE);
    done_o        = (state_q == ST_FINISH);
  end

endmodule

// File: rtl/core/lbps_datapath.sv
module lbps_datapath import lbps_pkg::*; #(
  parameter int unsigned MAX_ENTRIES   = 8,
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output status_t                    status_o,
  input  logic [1:0]                 opcode_i,
  input  logic [INDEX_W-1:0]         entry_index_i,
  input  logic signed [DUR_IN_W-1:0] duration_i,
  input  logic [COUNT_W-1:0]         entry_count_i,
  input  logic                       led_value_i,
  output logic                       led_on_o,
  output logic                       running_o,
  output logic                       pattern_valid_o
);

  localparam int unsigned IAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned UW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TW  = DURATION_BITS + $clog2(MAX_ENTRIES);

  // Captured request.
  opcode_e                    op_q;
  logic [INDEX_W-1:0]         eidx_q;
  logic signed [DUR_IN_W-1:0] dur_q;
  logic [COUNT_W-1:0]         cnt_q;
  logic                       lval_q;

  // Pattern state.
  logic [UW-1:0] used_q, used_d;
  logic [TW-1:0] total_q, total_d;
  logic [TW-1:0] elapsed_q, elapsed_d;
  logic          has_halt_q, has_halt_d;
  logic          halted_q, halted_d;
  logic          led_q, led_d;

  // Table walk state.
  logic [UW-1:0] idx_q, idx_d;
  logic [TW-1:0] cum_q, cum_d;
  logic          found_q, found_d;
  logic          par_q, par_d;

  // Duration table.
  logic [DURATION_BITS-1:0] mem [MAX_ENTRIES];
  logic [DURATION_BITS-1:0] rd_q;
  logic [IAW-1:0]           rd_addr;
  logic                     wr_ok;

  logic          v_neg, v_pos;
  logic [TW-1:0] v_mag, cum_sum, total_sum, el_inc;
  logic [UW-1:0] idx_inc, count_sat;
  logic          last_entry, pattern_ok, found_now, par_now;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_e'(opcode_i);
      eidx_q <= entry_index_i;
      dur_q  <= duration_i;
      cnt_q  <= entry_count_i;
      lval_q <= led_value_i;
    end
  end

  assign wr_ok   = (int'(eidx_q) < MAX_ENTRIES);
  assign rd_addr = (int'(idx_d) < MAX_ENTRIES) ? IAW'(idx_d) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (op_q == OP_WRITE) && wr_ok) begin
      mem[IAW'(eidx_q)] <= DURATION_BITS'(dur_q);
    end
    rd_q <= mem[rd_addr];
  end

  assign v_neg      = rd_q[DURATION_BITS-1];
  assign v_pos      = !v_neg && (rd_q != '0);
  assign v_mag      = TW'(rd_q[DURATION_BITS-2:0]);
  assign cum_sum    = cum_q + v_mag;
  assign total_sum  = total_q + v_mag;
  assign el_inc     = elapsed_q + TW'(1);
  assign idx_inc    = idx_q + UW'(1);
  assign last_entry = (idx_inc == used_q);
  assign pattern_ok = (used_q != '0) && (total_q != '0);
  assign found_now  = found_q || v_pos;
  assign par_now    = v_pos ? idx_q[0] : par_q;
  assign count_sat  = (int'(cnt_q) > MAX_ENTRIES) ? UW'(MAX_ENTRIES) : UW'(cnt_q);

  always_comb begin
    status_o = '0;
    case (op_q)
      OP_START: begin
        status_o.walk_needed = (count_sat != '0);
        status_o.walk_end    = v_neg || last_entry;
      end
      OP_TICK: begin
        status_o.walk_needed = pattern_ok && !halted_q;
        status_o.walk_end    = v_neg || (elapsed_q < cum_sum) || last_entry;
      end
      default: begin
        status_o = '0;
      end
    endcase
  end

  always_comb begin
    used_d     = used_q;
    total_d    = total_q;
    elapsed_d  = elapsed_q;
    has_halt_d = has_halt_q;
    halted_d   = halted_q;
    led_d      = led_q;
    idx_d      = idx_q;
    cum_d      = cum_q;
    found_d    = found_q;
    par_d      = par_q;

    if (cmd_i.exec) begin
      idx_d   = '0;
      cum_d   = '0;
      found_d = 1'b0;
      par_d   = 1'b0;
      case (op_q)
        OP_MANUAL: begin
          led_d = lval_q;
        end
        OP_START: begin
          used_d     = count_sat;
          total_d    = '0;
          elapsed_d  = '0;
          has_halt_d = 1'b0;
          halted_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.step) begin
      idx_d = idx_inc;
      case (op_q)
        OP_START: begin
          if (v_neg) begin
            has_halt_d = 1'b1;
          end else begin
            total_d = total_sum;
          end
        end
        OP_TICK: begin
          if (v_neg) begin
            // A halt entry freezes the pattern at the last lit parity.
            halted_d = 1'b1;
            if (found_q) begin
              led_d = !par_q;
            end
          end else begin
            found_d = found_now;
            par_d   = par_now;
            cum_d   = cum_sum;
            if (status_o.walk_end) begin
              if (found_now) begin
                led_d = !par_now;
              end
              if (has_halt_q) begin
                if (elapsed_q < total_q) begin
                  elapsed_d = el_inc;
                end
              end else begin
                elapsed_d = (el_inc >= total_q) ? '0 : el_inc;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      total_q    <= '0;
      elapsed_q  <= '0;
      has_halt_q <= 1'b0;
      halted_q   <= 1'b0;
      led_q      <= 1'b0;
      idx_q      <= '0;
      cum_q      <= '0;
      found_q    <= 1'b0;
      par_q      <= 1'b0;
    end else begin
      used_q     <= used_d;
      total_q    <= total_d;
      elapsed_q  <= elapsed_d;
      has_halt_q <= has_halt_d;
      halted_q   <= halted_d;
      led_q      <= led_d;
      idx_q      <= idx_d;
      cum_q      <= cum_d;
      found_q    <= found_d;
      par_q      <= par_d;
    end
  end

  assign led_on_o        = led_q;
  assign pattern_valid_o = pattern_ok;
  assign running_o       = pattern_ok && !halted_q;

endmodule

// File: rtl/core/lbps_checker.sv
`include "led_blink_pattern_sequencer_defines.svh"

module lbps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic running_o,
  input logic pattern_valid_o
);

  `LBPS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `LBPS_ASSERT_NXT(a_done_single, done_o, !done_o && !busy, "done strobe longer than one cycle")
  `LBPS_ASSERT_IMP(a_done_in_busy, done_o, busy, "done strobe outside a busy request")
  `LBPS_ASSERT_IMP(a_running_valid, running_o, pattern_valid_o, "running without valid pattern")

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .running_o       (running_o),
  .pattern_valid_o (pattern_valid_o)
);

// File: verif/led_blink_pattern_checker.sv
`timescale 1ns / 100ps

// Watches the request and result channels of the LED pattern sequencer, keeps
// its own copy of the pattern state and compares every result in order.
module led_blink_pattern_checker import lbps_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [1:0]                 opcode_i,
  input  logic [INDEX_W-1:0]         entry_index_i,
  input  logic signed [DUR_IN_W-1:0] duration_i,
  input  logic [COUNT_W-1:0]         entry_count_i,
  input  logic                       led_value_i,
  input  logic                       done_i,
  input  logic                       led_on_i,
  input  logic                       running_i,
  input  logic                       pattern_valid_i,
  output int                         fail_count_o,
  output int                         outstanding_o
);

  localparam int unsigned TABLE_DEPTH = 8;

  typedef struct packed {
    logic led_on;
    logic running;
    logic pattern_valid;
  } led_status_t;

  led_status_t                led_status_q [$];
  logic signed [DUR_IN_W-1:0] duration_table [TABLE_DEPTH];
  logic [COUNT_W-1:0]         used_count;
  logic [18:0]                total_ms;
  logic [18:0]                elapsed_ms;
  logic                       halt_in_pattern;
  logic                       halted;
  logic                       led_state;
  int                         mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one request to the local pattern state and queues the status the
  // block must show for it.
  task automatic predict_led_status(opcode_e op, logic [INDEX_W-1:0] idx,
                                    logic signed [DUR_IN_W-1:0] dur,
                                    logic [COUNT_W-1:0] cnt, logic led_val);
    logic [18:0] run_sum;
    int          last_nonzero;
    logic        valid;
    run_sum = '0;
    last_nonzero = -1;
    case (op)
      OP_TICK: begin
        if (used_count != 0 && total_ms != 0 && !halted) begin
          // Walk the live table until the elapsed time falls inside the sum.
          for (int i = 0; i < used_count; i++) begin
            if (duration_table[i] < 0) begin
              halted = 1'b1;
              break;
            end
            if (duration_table[i] > 0) last_nonzero = i;
            run_sum = run_sum + 19'(duration_table[i]);
            if (elapsed_ms < run_sum) break;
          end
          if (last_nonzero >= 0) led_state = (last_nonzero % 2 == 0);
          if (!halted) begin
            if (halt_in_pattern) begin
              if (elapsed_ms < total_ms) elapsed_ms = elapsed_ms + 19'd1;
            end else begin
              elapsed_ms = (elapsed_ms + 19'd1 >= total_ms) ? '0 : elapsed_ms + 19'd1;
            end
          end
        end
      end
      OP_WRITE: begin
        duration_table[idx] = dur;
      end
      OP_START: begin
        used_count = (cnt > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : cnt;
        halted = 1'b0;
        elapsed_ms = '0;
        halt_in_pattern = 1'b0;
        total_ms = '0;
        for (int i = 0; i < used_count; i++) begin
          if (duration_table[i] < 0) begin
            halt_in_pattern = 1'b1;
            break;
          end
          total_ms = total_ms + 19'(duration_table[i]);
        end
      end
      default: begin
        led_state = led_val;
      end
    endcase
    valid = (used_count != 0) && (total_ms != 0);
    led_status_q.push_back('{led_on: led_state, running: valid && !halted,
                             pattern_valid: valid});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    led_status_t expected;
    if (!rst_ni) begin
      led_status_q.delete();
      foreach (duration_table[i]) duration_table[i] = '0;
      used_count = '0;
      total_ms = '0;
      elapsed_ms = '0;
      halt_in_pattern = 1'b0;
      halted = 1'b0;
      led_state = 1'b0;
      outstanding_o <= 0;
    end else begin
      // A result always ends before the next request can be taken, so the
      // result is checked first.
      if (done_i) begin
        if (led_status_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          expected = led_status_q.pop_front();
          if (led_on_i !== expected.led_on)
            report_mismatch($sformatf("led_on expected %0b got %0b",
                                      expected.led_on, led_on_i));
          if (running_i !== expected.running)
            report_mismatch($sformatf("running expected %0b got %0b",
                                      expected.running, running_i));
          if (pattern_valid_i !== expected.pattern_valid)
            report_mismatch($sformatf("pattern_valid expected %0b got %0b",
                                      expected.pattern_valid, pattern_valid_i));
        end
      end
      if (start_i && !busy_i) begin
        predict_led_status(opcode_e'(opcode_i), entry_index_i, duration_i,
                           entry_count_i, led_value_i);
      end
      outstanding_o <= led_status_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

// Top level of the LED pattern sequencer testbench. It resets the block once,
// sends a short directed run of requests and then random pattern sequences,
// and gives the verdict. Results are checked by the checker instance.
module testbench;
  import lbps_pkg::*;

  // Roughly this many requests are sent before the run winds down.
  localparam int unsigned TARGET_REQUESTS = 1800;
  // A start or a live tick walks at most eight entries and draw_gap bounds the
  // sender's wait, so reaching IDLE_LIMIT with nothing moving means a hang.
  localparam int unsigned IDLE_LIMIT = 1000;
  // Quiet time after the last result, long enough to catch a stray result.
  localparam int unsigned SETTLE_CYCLES = 12;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  opcode_e                    opcode;
  logic [INDEX_W-1:0]         entry_index;
  logic signed [DUR_IN_W-1:0] duration;
  logic [COUNT_W-1:0]         entry_count;
  logic                       led_value;
  logic                       done_o;
  logic                       led_on_o;
  logic                       running_o;
  logic                       pattern_valid_o;
  int                         fail_count;
  int                         outstanding;
  int unsigned                requests_sent = 0;
  int unsigned                idle_cycles = 0;
  // When set, the sender issues back to back with no gaps.
  logic                       back_to_back = 1'b0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  led_blink_pattern_sequencer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode),
    .entry_index_i   (entry_index),
    .duration_i      (duration),
    .entry_count_i   (entry_count),
    .led_value_i     (led_value),
    .done_o          (done_o),
    .led_on_o        (led_on_o),
    .running_o       (running_o),
    .pattern_valid_o (pattern_valid_o)
  );

  led_blink_pattern_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .opcode_i        (opcode),
    .entry_index_i   (entry_index),
    .duration_i      (duration),
    .entry_count_i   (entry_count),
    .led_value_i     (led_value),
    .done_i          (done_o),
    .led_on_i        (led_on_o),
    .running_i       (running_o),
    .pattern_valid_i (pattern_valid_o),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  // Cycles the sender waits before the next request.
  function automatic int unsigned draw_gap();
    return back_to_back ? 0 : $urandom_range(0, 5);
  endfunction

  // Mostly short durations so that patterns wrap and halt within a few dozen
  // ticks, with zero entries, halt entries and the full 16-bit range mixed in.
  function automatic logic signed [DUR_IN_W-1:0] pick_duration();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return DUR_IN_W'($urandom_range(1, 6));
    if (pick < 15) return '0;
    if (pick < 17) return DUR_IN_W'($urandom_range(65532, 65535));
    if (pick < 19) return DUR_IN_W'($urandom_range(0, 65535));
    return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
  endfunction

  // Sends one request and returns at the edge that accepts it. The start
  // strobe is left high so that a following request with no gap keeps it up.
  task automatic send_request(int unsigned gap, opcode_e op, logic [INDEX_W-1:0] idx,
                              logic signed [DUR_IN_W-1:0] dur,
                              logic [COUNT_W-1:0] cnt, logic led);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    duration    <= dur;
    entry_count <= cnt;
    led_value   <= led;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests_sent++;
  endtask

  // Holds the sender off until every queued result has come back. The first
  // edge lets the checker count the request that was just accepted.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // A tick carries random values in the fields it does not use.
  task automatic send_tick();
    send_request(draw_gap(), OP_TICK, INDEX_W'($urandom_range(0, 7)),
                 DUR_IN_W'($urandom_range(0, 65535)), COUNT_W'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic signed [DUR_IN_W-1:0] first_table [8];
    int unsigned                pick;
    int unsigned                tick_count;
    logic [COUNT_W-1:0]         count;

    first_table = '{16'sd0, 16'sd0, 16'sh8000, 16'sh7fff, 16'sd1, 16'sd0, 16'sd2, 16'sd3};
    start       <= 1'b0;
    opcode      <= OP_TICK;
    entry_index <= '0;
    duration    <= '0;
    entry_count <= '0;
    led_value   <= 1'b0;
    rst_ni      <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Nothing may walk the table before every entry has been
    // written, so the first requests use no entries at all.
    send_request(draw_gap(), OP_MANUAL, 3'd0, 16'sd0, 4'd0, 1'b1);
    // A tick with no pattern loaded leaves the LED alone.
    send_tick();
    // A start with a zero count gives an invalid pattern.
    send_request(draw_gap(), OP_START, 3'd0, 16'sd0, 4'd0, 1'b0);
    send_request(draw_gap(), OP_MANUAL, 3'd0, 16'sd0, 4'd0, 1'b0);
    for (int i = 0; i < 8; i++)
      send_request(draw_gap(), OP_WRITE, INDEX_W'(i), first_table[i], 4'd0, 1'b0);
    // Two zero entries: no time at all, so the pattern is invalid.
    send_request(draw_gap(), OP_START, 3'd0, 16'sd0, 4'd2, 1'b0);
    send_tick();
    // Zero time before a halt entry is invalid as well.
    send_request(draw_gap(), OP_START, 3'd0, 16'sd0, 4'd3, 1'b0);
    // One on-time, a skipped zero, then a halt: the LED stays on once halted.
    send_request(draw_gap(), OP_WRITE, 3'd0, 16'sd1, 4'd0, 1'b0);
    send_request(draw_gap(), OP_START, 3'd0, 16'sd0, 4'd3, 1'b0);
    repeat (3) send_tick();
    // Remove the halt and start with an oversized count, which saturates.
    send_request(draw_gap(), OP_WRITE, 3'd2, 16'sd2, 4'd0, 1'b0);
    send_request(draw_gap(), OP_START, 3'd0, 16'sd0, 4'd15, 1'b1);
    send_tick();
    // A manual override holds only until the next tick of a running pattern.
    send_request(draw_gap(), OP_MANUAL, 3'd7, 16'sd0, 4'd0, 1'b0);
    send_tick();
    // Edit the live table: a halt entry appears behind the current position.
    send_request(draw_gap(), OP_WRITE, 3'd1, 16'shffff, 4'd0, 1'b0);
    send_tick();

    // Let everything settle once before the random part.
    wait_for_drain();

    // Random part: mostly complete sequences of table writes, a start and a
    // run of ticks, with overrides and live edits mixed into the ticks, plus
    // short bursts of fully random requests.
    while (requests_sent < TARGET_REQUESTS) begin
      back_to_back = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 8))
          send_request(draw_gap(), OP_WRITE, INDEX_W'($urandom_range(0, 7)),
                       pick_duration(), COUNT_W'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 9);
        if (pick == 0) count = '0;
        else if (pick == 1) count = COUNT_W'($urandom_range(9, 15));
        else count = COUNT_W'($urandom_range(1, 8));
        send_request(draw_gap(), OP_START, INDEX_W'($urandom_range(0, 7)),
                     DUR_IN_W'($urandom_range(0, 65535)), count,
                     1'($urandom_range(0, 1)));
        tick_count = $urandom_range(4, 48);
        repeat (tick_count) begin
          pick = $urandom_range(0, 19);
          if (pick == 0)
            send_request(draw_gap(), OP_MANUAL, INDEX_W'($urandom_range(0, 7)),
                         DUR_IN_W'($urandom_range(0, 65535)),
                         COUNT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
          else if (pick == 1)
            send_request(draw_gap(), OP_WRITE, INDEX_W'($urandom_range(0, 7)),
                         pick_duration(), COUNT_W'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)));
          else
            send_tick();
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_request(draw_gap(), opcode_e'($urandom_range(0, 3)),
                       INDEX_W'($urandom_range(0, 7)),
                       DUR_IN_W'($urandom_range(0, 65535)),
                       COUNT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Ends the run if neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
